// File: hdl/clfp_pkg.sv
// Package for the content-length frame parser: shared constants, codes,
// item and result types, and small character helper functions.
// No dependencies.
package clfp_pkg;

  localparam int unsigned MAX_LINE_LENGTH = 8192;
  localparam int unsigned LENGTH_BITS     = 32;
  localparam int unsigned CFG_WIDTH       = 32;

  localparam logic [CFG_WIDTH-1:0] MAX_PAYLOAD_RESET = '1;

  // Length of the matched header name "content-length".
  localparam logic [3:0] NAME_LEN = 4'd14;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  typedef enum logic [1:0] {
    PH_LINE    = 2'd0,
    PH_CR      = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MALFORMED = 3'd0,
    ERR_INVALID   = 3'd1,
    ERR_TOO_LARGE = 3'd2,
    ERR_MISSING   = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic       last;
    err_e       error_code;
  } result_t;

  // Characters of the header name, lower case.
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] lower_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// File: hdl/clfp_in_if.sv
// Input channel interface of the content-length frame parser.
// Depends on nothing.
interface clfp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

// File: hdl/clfp_out_if.sv
// Result channel interface of the content-length frame parser.
// Depends on nothing.
interface clfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       last;
  logic [2:0] error_code;

  modport source (output valid, output kind, output payload_byte, output last,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input payload_byte, input last,
                  input error_code, output ready);
endinterface

// File: hdl/clfp_cfg_if.sv
// Configuration write channel interface of the content-length frame parser.
// Depends on clfp_pkg for the register width.
interface clfp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [clfp_pkg::CFG_WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/clfp_in_stage.sv
// Input register of the content-length frame parser.
// Depends on clfp_pkg for the item type.
module clfp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  clfp_pkg::item_t in_item_i,
  output logic            in_ready_o,
  input  logic            take_i,
  output logic            item_valid_o,
  output clfp_pkg::item_t item_o
);

  logic            valid_q;
  clfp_pkg::item_t item_q;

  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

// File: hdl/clfp_parser.sv
// Parser state and single-pass update logic of the content-length frame
// parser. Depends on clfp_pkg for codes, types and character helpers.
module clfp_parser #(
  parameter int unsigned MAX_LINE_LENGTH = clfp_pkg::MAX_LINE_LENGTH,
  parameter int unsigned LENGTH_BITS     = clfp_pkg::LENGTH_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  clfp_pkg::item_t                item_i,
  input  logic                           slot_free_i,
  input  logic [clfp_pkg::CFG_WIDTH-1:0] max_len_i,
  output logic                           take_o,
  output logic                           res_valid_o,
  output clfp_pkg::result_t              res_o
);

  localparam int unsigned LLW = $clog2(MAX_LINE_LENGTH + 1);
  localparam int unsigned AW  = LENGTH_BITS + 4;
  localparam int unsigned CW  = (LENGTH_BITS > clfp_pkg::CFG_WIDTH) ?
                                LENGTH_BITS : clfp_pkg::CFG_WIDTH;

  clfp_pkg::phase_e         phase_q, phase_d;
  logic [LLW-1:0]           line_len_q, line_len_d;
  logic                     any_seen_q, any_seen_d;
  logic                     colon_q, colon_d;
  logic                     name_ne_q, name_ne_d;
  logic                     name_trail_q, name_trail_d;
  logic [3:0]               match_idx_q, match_idx_d;
  logic                     mismatch_q, mismatch_d;
  logic                     val_started_q, val_started_d;
  logic                     val_trail_q, val_trail_d;
  logic                     val_bad_q, val_bad_d;
  logic                     too_big_q, too_big_d;
  logic [LENGTH_BITS-1:0]   accum_q, accum_d;
  logic                     len_known_q, len_known_d;
  logic [LENGTH_BITS-1:0]   remain_q, remain_d;

  logic                     fire;
  logic                     frame_clr;
  logic                     line_clr;
  logic [7:0]               c;
  logic                     blank;
  logic [AW-1:0]            accum_next;
  logic                     name_match;
  logic                     last;

  assign fire   = item_valid_i && slot_free_i;
  assign take_o = fire;
  assign c      = item_i.data_byte;
  assign blank  = (c == clfp_pkg::CH_SPACE) || (c == clfp_pkg::CH_TAB);
  // Digits are 0x30..0x39, so the low nibble is the digit value.
  assign accum_next = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + AW'(c[3:0]);
  assign name_match = !mismatch_q && (match_idx_q == clfp_pkg::NAME_LEN);

  always_comb begin
    phase_d       = phase_q;
    line_len_d    = line_len_q;
    any_seen_d    = any_seen_q;
    colon_d       = colon_q;
    name_ne_d     = name_ne_q;
    name_trail_d  = name_trail_q;
    match_idx_d   = match_idx_q;
    mismatch_d    = mismatch_q;
    val_started_d = val_started_q;
    val_trail_d   = val_trail_q;
    val_bad_d     = val_bad_q;
    too_big_d     = too_big_q;
    accum_d       = accum_q;
    len_known_d   = len_known_q;
    remain_d      = remain_q;
    frame_clr     = 1'b0;
    line_clr      = 1'b0;
    last          = 1'b0;
    res_valid_o   = 1'b0;
    res_o         = '0;

    if (fire) begin
      if (item_i.mode) begin
        res_valid_o = 1'b1;
        frame_clr   = 1'b1;
        if (phase_q == clfp_pkg::PH_PAYLOAD) begin
          res_o.kind       = clfp_pkg::KIND_ERROR;
          res_o.error_code = clfp_pkg::ERR_TRUNCATED;
        end else if (phase_q == clfp_pkg::PH_CR || line_len_q != '0 || any_seen_q) begin
          res_o.kind       = clfp_pkg::KIND_ERROR;
          res_o.error_code = clfp_pkg::ERR_MALFORMED;
        end else begin
          res_o.kind = clfp_pkg::KIND_END;
        end
      end else begin
        case (phase_q)
          clfp_pkg::PH_PAYLOAD: begin
            last               = (remain_q <= LENGTH_BITS'(1));
            res_valid_o        = 1'b1;
            res_o.kind         = clfp_pkg::KIND_PAYLOAD;
            res_o.payload_byte = c;
            res_o.last         = last;
            if (last) begin
              frame_clr = 1'b1;
            end else begin
              remain_d = remain_q - LENGTH_BITS'(1);
            end
          end
          clfp_pkg::PH_CR: begin
            if (c != clfp_pkg::CH_LF) begin
              res_valid_o      = 1'b1;
              res_o.kind       = clfp_pkg::KIND_ERROR;
              res_o.error_code = clfp_pkg::ERR_MALFORMED;
              frame_clr        = 1'b1;
            end else begin
              // End of a header line.
              phase_d = clfp_pkg::PH_LINE;
              if (line_len_q == '0) begin
                if (!len_known_q) begin
                  res_valid_o      = 1'b1;
                  res_o.kind       = clfp_pkg::KIND_ERROR;
                  res_o.error_code = clfp_pkg::ERR_MISSING;
                  frame_clr        = 1'b1;
                end else if (remain_q == '0) begin
                  res_valid_o = 1'b1;
                  res_o.kind  = clfp_pkg::KIND_EMPTY;
                  frame_clr   = 1'b1;
                end else begin
                  phase_d = clfp_pkg::PH_PAYLOAD;
                end
              end else begin
                any_seen_d = 1'b1;
                line_clr   = 1'b1;
                if (!colon_q || !name_ne_q) begin
                  res_valid_o      = 1'b1;
                  res_o.kind       = clfp_pkg::KIND_ERROR;
                  res_o.error_code = clfp_pkg::ERR_MALFORMED;
                  frame_clr        = 1'b1;
                end else if (name_match) begin
                  if (len_known_q || !val_started_q || val_bad_q) begin
                    res_valid_o      = 1'b1;
                    res_o.kind       = clfp_pkg::KIND_ERROR;
                    res_o.error_code = clfp_pkg::ERR_INVALID;
                    frame_clr        = 1'b1;
                  end else if (too_big_q || (CW'(accum_q) > CW'(max_len_i))) begin
                    res_valid_o      = 1'b1;
                    res_o.kind       = clfp_pkg::KIND_ERROR;
                    res_o.error_code = clfp_pkg::ERR_TOO_LARGE;
                    frame_clr        = 1'b1;
                  end else begin
                    len_known_d = 1'b1;
                    remain_d    = accum_q;
                  end
                end
              end
            end
          end
          clfp_pkg::PH_LINE: begin
            if (c == clfp_pkg::CH_LF) begin
              res_valid_o      = 1'b1;
              res_o.kind       = clfp_pkg::KIND_ERROR;
              res_o.error_code = clfp_pkg::ERR_MALFORMED;
              frame_clr        = 1'b1;
            end else if (c == clfp_pkg::CH_CR) begin
              phase_d = clfp_pkg::PH_CR;
            end else if (line_len_q >= LLW'(MAX_LINE_LENGTH)) begin
              res_valid_o      = 1'b1;
              res_o.kind       = clfp_pkg::KIND_ERROR;
              res_o.error_code = clfp_pkg::ERR_MALFORMED;
              frame_clr        = 1'b1;
            end else begin
              line_len_d = line_len_q + LLW'(1);
              if (!colon_q) begin
                if (c == clfp_pkg::CH_COLON) begin
                  colon_d = 1'b1;
                end else if (blank) begin
                  if (name_ne_q) begin
                    name_trail_d = 1'b1;
                  end
                end else begin
                  // A name character after inner whitespace spoils the match.
                  if (name_trail_q) begin
                    mismatch_d   = 1'b1;
                    name_trail_d = 1'b0;
                  end
                  if (match_idx_q < clfp_pkg::NAME_LEN &&
                      clfp_pkg::lower_char(c) == clfp_pkg::key_char(match_idx_q)) begin
                    match_idx_d = match_idx_q + 4'd1;
                  end else begin
                    mismatch_d = 1'b1;
                  end
                  name_ne_d = 1'b1;
                end
              end else if (blank) begin
                if (val_started_q) begin
                  val_trail_d = 1'b1;
                end
              end else begin
                if (val_trail_q || c < clfp_pkg::CH_ZERO || c > clfp_pkg::CH_NINE) begin
                  val_bad_d = 1'b1;
                end else if (!too_big_q) begin
                  if (accum_next[AW-1:LENGTH_BITS] != '0) begin
                    too_big_d = 1'b1;
                  end else begin
                    accum_d = accum_next[LENGTH_BITS-1:0];
                  end
                end
                val_started_d = 1'b1;
              end
            end
          end
          default: begin
            frame_clr = 1'b1;
          end
        endcase
      end
    end

    if (line_clr || frame_clr) begin
      line_len_d    = '0;
      colon_d       = 1'b0;
      name_ne_d     = 1'b0;
      name_trail_d  = 1'b0;
      match_idx_d   = 4'd0;
      mismatch_d    = 1'b0;
      val_started_d = 1'b0;
      val_trail_d   = 1'b0;
      val_bad_d     = 1'b0;
      too_big_d     = 1'b0;
      accum_d       = '0;
    end
    if (frame_clr) begin
      phase_d     = clfp_pkg::PH_LINE;
      any_seen_d  = 1'b0;
      len_known_d = 1'b0;
      remain_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= clfp_pkg::PH_LINE;
      line_len_q    <= '0;
      any_seen_q    <= 1'b0;
      colon_q       <= 1'b0;
      name_ne_q     <= 1'b0;
      name_trail_q  <= 1'b0;
      match_idx_q   <= 4'd0;
      mismatch_q    <= 1'b0;
      val_started_q <= 1'b0;
      val_trail_q   <= 1'b0;
      val_bad_q     <= 1'b0;
      too_big_q     <= 1'b0;
      accum_q       <= '0;
      len_known_q   <= 1'b0;
      remain_q      <= '0;
    end else begin
      phase_q       <= phase_d;
      line_len_q    <= line_len_d;
      any_seen_q    <= any_seen_d;
      colon_q       <= colon_d;
      name_ne_q     <= name_ne_d;
      name_trail_q  <= name_trail_d;
      match_idx_q   <= match_idx_d;
      mismatch_q    <= mismatch_d;
      val_started_q <= val_started_d;
      val_trail_q   <= val_trail_d;
      val_bad_q     <= val_bad_d;
      too_big_q     <= too_big_d;
      accum_q       <= accum_d;
      len_known_q   <= len_known_d;
      remain_q      <= remain_d;
    end
  end

endmodule

// File: hdl/clfp_out_reg.sv
// Result register of the content-length frame parser.
// Depends on clfp_pkg for the result type.
module clfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  clfp_pkg::result_t res_i,
  output logic              slot_free_o,
  output logic              out_valid_o,
  output clfp_pkg::result_t out_res_o,
  input  logic              out_ready_i
);

  logic              valid_q;
  clfp_pkg::result_t res_q;

  assign slot_free_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: hdl/content_length_frame_parser_top.sv
// Top level of the content-length frame parser.
// Depends on clfp_pkg, the three channel interfaces, clfp_in_stage,
// clfp_parser and clfp_out_reg.

// The parser takes one item per clock cycle, sustained unless a result
// waits unaccepted in the output register: each item is either a stream
// byte or an end-of-stream marker, and it gives at most one result. An
// accepted item sits in the input register; once the output register can
// take a result, a single pass of flag and counter logic updates the parser
// state and loads the result, if any, into the output register. The output
// register is the only point of back-pressure: while a result waits there
// unaccepted, the item in the input register stays put and the input
// stalls, though an empty input register still takes one item. Header lines
// end in CR LF; the Content-Length header (case-insensitive, spaces and tabs
// trimmed) sets how many payload bytes follow the blank line. Those bytes
// come out with the final one marked last, or a single empty-frame result
// when the length is zero. Any error is reported once and parsing restarts at
// a fresh frame. The largest accepted length is a register written through
// the configuration channel, which is always ready; write it only while no
// item is in flight. It resets to all ones.
module content_length_frame_parser_top #(
  parameter int unsigned MAX_LINE_LENGTH = clfp_pkg::MAX_LINE_LENGTH,
  parameter int unsigned LENGTH_BITS     = clfp_pkg::LENGTH_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clfp_in_if.sink      in_i,
  clfp_out_if.source   out_o,
  clfp_cfg_if.sink     cfg_i
);

  logic [clfp_pkg::CFG_WIDTH-1:0] max_len_q;

  clfp_pkg::item_t   in_item;
  clfp_pkg::item_t   item;
  logic              item_valid;
  logic              take;
  logic              slot_free;
  logic              res_valid;
  clfp_pkg::result_t res;
  clfp_pkg::result_t out_res;

  // The length limit register accepts a write in any cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= clfp_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.data;
    end
  end

  assign in_item.mode      = in_i.mode;
  assign in_item.data_byte = in_i.data_byte;

  clfp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (in_i.ready),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  clfp_parser #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .slot_free_i  (slot_free),
    .max_len_i    (max_len_q),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // A result is loaded only in a cycle where the parser consumes its item.
  clfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid && take),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_o.valid),
    .out_res_o   (out_res),
    .out_ready_i (out_o.ready)
  );

  assign out_o.kind         = out_res.kind;
  assign out_o.payload_byte = out_res.payload_byte;
  assign out_o.last         = out_res.last;
  assign out_o.error_code   = out_res.error_code;

endmodule

// File: hdl/clfp_checker.sv
// Port-level checks for the content-length frame parser, and the bind that
// attaches them to the top level. Depends on clfp_pkg for result codes.
module clfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic [7:0] payload_byte_i,
  input logic       last_i,
  input logic [2:0] error_code_i
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(payload_byte_i)
      && $stable(last_i) && $stable(error_code_i))
    else $error("result changed while stalled");

  // With the output register empty, the input side never stalls.
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  // Only payload results carry a byte or a last mark.
  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != clfp_pkg::KIND_PAYLOAD |-> payload_byte_i == 8'd0 && !last_i)
    else $error("payload fields set on a non-payload result");

  // Only error results carry an error code.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != clfp_pkg::KIND_ERROR |-> error_code_i == 3'd0)
    else $error("error code set on a non-error result");

  // Error codes stay within the defined set.
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == clfp_pkg::KIND_ERROR |-> error_code_i <= clfp_pkg::ERR_TRUNCATED)
    else $error("undefined error code");

endmodule

bind content_length_frame_parser_top clfp_checker u_clfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .payload_byte_i (out_o.payload_byte),
  .last_i         (out_o.last),
  .error_code_i   (out_o.error_code)
);
